@@ rtl/rtmpche_pkg.sv @@
// Shared types and constants for the RTMP chunk header encoder.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package rtmpche_pkg;

  localparam logic [23:0] TIME_FIELD_MAX = 24'hFFFFFF;
  localparam logic [16:0] BASIC_ONE_MAX  = 17'd63;
  localparam logic [16:0] BASIC_TWO_MAX  = 17'd319;
  localparam logic [16:0] BASIC_OFFSET   = 17'd64;
  localparam logic [16:0] CSID_RESET     = 17'd3;
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  // Chunk header formats
  localparam logic [1:0] FMT_FULL    = 2'd0;
  localparam logic [1:0] FMT_SAME_ID = 2'd1;
  localparam logic [1:0] FMT_TIME    = 2'd2;
  localparam logic [1:0] FMT_NONE    = 2'd3;

  // Basic header id forms
  localparam logic [5:0] BASIC_ID_TWO   = 6'd0;
  localparam logic [5:0] BASIC_ID_THREE = 6'd1;

  // Register word index on the configuration port
  localparam logic REG_CHUNK_STREAM_ID = 1'b0;

  // One classified message, ready for serialization
  typedef struct packed {
    logic [23:0] basic;      // basic header bytes, first byte in [7:0]
    logic [1:0]  basic_len;  // 1 to 3
    logic [3:0]  msg_len;    // 11, 7, 3 or 0
    logic        ext;        // extended timestamp follows
    logic [4:0]  last_idx;   // index of final header byte
    logic [23:0] time_field;
    logic [31:0] time_sent;
    logic [23:0] length;
    logic [7:0]  kind;
    logic [31:0] stream;
  } job_t;

  function automatic logic [3:0] msg_header_len(input logic [1:0] fmt);
    logic [3:0] len;
    unique case (fmt)
      FMT_FULL:    len = 4'd11;
      FMT_SAME_ID: len = 4'd7;
      FMT_TIME:    len = 4'd3;
      default:     len = 4'd0;
    endcase
    return len;
  endfunction

endpackage

@@ rtl/rtmpche_front.sv @@
// Front end: accepts message descriptors, compares them with the previous
// message and builds a classified job. Depends on rtmpche_pkg.
`timescale 1ns / 1ps
module rtmpche_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic [7:0]          in_message_type,
  input  logic [31:0]         in_timestamp,
  input  logic [23:0]         in_message_length,
  input  logic [31:0]         in_stream_id,
  input  logic                in_payload_given,
  input  logic [16:0]         csid,
  output rtmpche_pkg::job_t   job
);
  import rtmpche_pkg::*;

  logic        hist_valid_r;
  logic [31:0] last_stream_r;
  logic [31:0] last_time_r;
  logic [31:0] last_delta_r;
  logic [7:0]  last_kind_r;
  logic [23:0] last_length_r;

  logic        same_stream;
  logic [31:0] t;
  logic [1:0]  fmt;
  logic [16:0] id_off;
  logic        ext;
  logic [3:0]  mlen;

  always_comb begin
    same_stream = hist_valid_r && (in_stream_id == last_stream_r) &&
                  (in_timestamp >= last_time_r);
    t   = same_stream ? (in_timestamp - last_time_r) : in_timestamp;
    fmt = FMT_FULL;
    if (same_stream) begin
      fmt = FMT_SAME_ID;
      if ((in_message_type == last_kind_r) && in_payload_given &&
          (in_message_length == last_length_r)) begin
        fmt = (t == last_delta_r) ? FMT_NONE : FMT_TIME;
      end
    end
    ext  = (t[31:24] != 8'd0) || (t[23:0] == TIME_FIELD_MAX);
    mlen = msg_header_len(fmt);
    id_off = csid - BASIC_OFFSET;

    job = '0;
    if (csid > BASIC_TWO_MAX) begin
      job.basic     = {id_off[15:8], id_off[7:0], fmt, BASIC_ID_THREE};
      job.basic_len = 2'd3;
    end else if (csid > BASIC_ONE_MAX) begin
      job.basic     = {8'd0, id_off[7:0], fmt, BASIC_ID_TWO};
      job.basic_len = 2'd2;
    end else begin
      job.basic     = {16'd0, fmt, csid[5:0]};
      job.basic_len = 2'd1;
    end
    job.msg_len    = mlen;
    job.ext        = ext;
    job.last_idx   = 5'({3'd0, job.basic_len} + {1'b0, mlen} + (ext ? 5'd4 : 5'd0) - 5'd1);
    job.time_field = ext ? TIME_FIELD_MAX : t[23:0];
    job.time_sent  = t;
    job.length     = in_message_length;
    job.kind       = in_message_type;
    job.stream     = in_stream_id;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_valid_r  <= 1'b0;
      last_stream_r <= '0;
      last_time_r   <= '0;
      last_delta_r  <= '0;
      last_kind_r   <= '0;
      last_length_r <= '0;
    end else if (accept) begin
      hist_valid_r  <= 1'b1;
      last_stream_r <= in_stream_id;
      last_time_r   <= in_timestamp;
      last_delta_r  <= t;
      last_kind_r   <= in_message_type;
      last_length_r <= in_message_length;
    end
  end

endmodule

@@ rtl/rtmpche_queue.sv @@
// Short job queue between the front end and the byte serializer.
// Register-based FIFO of rtmpche_pkg::job_t entries.
`timescale 1ns / 1ps
module rtmpche_queue #(
  parameter int unsigned DEPTH = rtmpche_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  rtmpche_pkg::job_t wr_data,
  input  logic              rd_en,
  output rtmpche_pkg::job_t rd_data,
  output logic              q_valid,
  output logic              q_full
);
  import rtmpche_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  job_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_wr, do_rd;

  assign q_valid = (count_r != '0);
  assign q_full  = (count_r == CW'(DEPTH));
  assign rd_data = mem_r[rd_ptr_r];
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && q_valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count_r <= count_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst_n) begin
      assert (count_r <= CW'(DEPTH))
        else $error("job queue count exceeds depth");
    end
  end

endmodule

@@ rtl/rtmpche_back.sv @@
// Back end: takes classified jobs from the queue and emits header bytes one
// per cycle, stalled by pop, via an output register. Depends on rtmpche_pkg.
`timescale 1ns / 1ps
module rtmpche_back (
  input  logic              clk,
  input  logic              rst_n,
  input  rtmpche_pkg::job_t q_data,
  input  logic              q_valid,
  output logic              q_pop,
  input  logic              pop,
  output logic              empty,
  output logic [7:0]        out_header_byte,
  output logic              out_last_byte
);
  import rtmpche_pkg::*;

  job_t       job_r;
  logic       cur_valid_r;
  logic [4:0] idx_r;
  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       out_last_r;

  logic       out_ready;
  logic       adv;
  logic       is_last;
  logic [4:0] msg_idx;
  logic [4:0] ext_idx;
  logic [7:0] cur_byte;

  assign out_ready = !out_valid_r || pop;
  assign adv       = cur_valid_r && out_ready;
  assign is_last   = (idx_r == job_r.last_idx);
  assign q_pop     = q_valid && (!cur_valid_r || (adv && is_last));

  always_comb begin
    msg_idx  = idx_r - {3'd0, job_r.basic_len};
    ext_idx  = msg_idx - {1'b0, job_r.msg_len};
    cur_byte = 8'd0;
    if (idx_r < {3'd0, job_r.basic_len}) begin
      case (idx_r[1:0])
        2'd0:    cur_byte = job_r.basic[7:0];
        2'd1:    cur_byte = job_r.basic[15:8];
        default: cur_byte = job_r.basic[23:16];
      endcase
    end else if (msg_idx < {1'b0, job_r.msg_len}) begin
      case (msg_idx[3:0])
        4'd0:    cur_byte = job_r.time_field[23:16];
        4'd1:    cur_byte = job_r.time_field[15:8];
        4'd2:    cur_byte = job_r.time_field[7:0];
        4'd3:    cur_byte = job_r.length[23:16];
        4'd4:    cur_byte = job_r.length[15:8];
        4'd5:    cur_byte = job_r.length[7:0];
        4'd6:    cur_byte = job_r.kind;
        4'd7:    cur_byte = job_r.stream[7:0];
        4'd8:    cur_byte = job_r.stream[15:8];
        4'd9:    cur_byte = job_r.stream[23:16];
        default: cur_byte = job_r.stream[31:24];
      endcase
    end else begin
      case (ext_idx[1:0])
        2'd0:    cur_byte = job_r.time_sent[31:24];
        2'd1:    cur_byte = job_r.time_sent[23:16];
        2'd2:    cur_byte = job_r.time_sent[15:8];
        default: cur_byte = job_r.time_sent[7:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      job_r <= q_data;
    end
    if (adv) begin
      out_byte_r <= cur_byte;
      out_last_r <= is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        cur_valid_r <= 1'b1;
        idx_r       <= '0;
      end else if (adv) begin
        // advance within the job, drop it after its final byte
        cur_valid_r <= !is_last;
        idx_r       <= is_last ? 5'd0 : idx_r + 5'd1;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign empty           = !out_valid_r;
  assign out_header_byte = out_byte_r;
  assign out_last_byte   = out_last_r;

  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cur_valid_r |-> (idx_r <= job_r.last_idx))
    else $error("byte index past end of header");

  a_job_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && !is_last) |=> (cur_valid_r && (idx_r == $past(idx_r) + 5'd1)))
    else $error("job dropped before its final byte");

  a_job_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (q_valid && !cur_valid_r) |=> (cur_valid_r && (idx_r == 5'd0)))
    else $error("waiting job not taken by idle serializer");

  a_last_len: assert property (@(posedge clk) disable iff (!rst_n)
    cur_valid_r |-> (job_r.last_idx <= 5'd17))
    else $error("header longer than eighteen bytes");

endmodule

@@ rtl/rtmp_chunk_header_encoder_core.sv @@
// RTMP chunk header encoder, top level: configuration register, front end,
// job queue and byte serializer. Depends on rtmpche_pkg and all rtmpche_*.
//
// Usage:
//   Input channel: a message descriptor (type, timestamp, length, stream id,
//   payload flag) is taken when push is high and full is low.
//   Result channel: header bytes come out in transmission order, one per
//   pop, while empty is low; out_last_byte marks the final byte of a header.
//   Configuration: APB register 0 at byte address 0 holds the 17-bit chunk
//   stream id (reset 3); write it only while the block is idle.
// Timing:
//   The first byte reaches the result ports through the job queue, the
//   job register and the output register. A header is 1 to 18 bytes,
//   one per pop through the single-byte output register; the front end
//   classifies one descriptor per cycle, while full is low, into a job
//   queue of QUEUE_DEPTH entries, so input is taken while earlier headers drain.
// Reset: clears message history (the next header is format 0), empties the
//   queue and output, and loads chunk stream id 3.
// Stall: with pop low the current byte holds; the queue fills and full rises.
`timescale 1ns / 1ps
module rtmp_chunk_header_encoder_core #(
  parameter int unsigned QUEUE_DEPTH = rtmpche_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_message_type,
  input  logic [31:0] in_timestamp,
  input  logic [23:0] in_message_length,
  input  logic [31:0] in_stream_id,
  input  logic        in_payload_given,
  input  logic        pop,
  output logic        empty,
  output logic [7:0]  out_header_byte,
  output logic        out_last_byte,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import rtmpche_pkg::*;

  logic [16:0] csid_r;
  logic        in_accept;
  job_t        front_job;
  job_t        q_head;
  logic        q_valid;
  logic        q_full;
  logic        q_pop;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_CHUNK_STREAM_ID) ? {15'd0, csid_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      csid_r <= CSID_RESET;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[2] == REG_CHUNK_STREAM_ID)) begin
      csid_r <= pwdata[16:0];
    end
  end

  assign full      = q_full;
  assign in_accept = push && !q_full;

  rtmpche_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .accept            (in_accept),
    .in_message_type   (in_message_type),
    .in_timestamp      (in_timestamp),
    .in_message_length (in_message_length),
    .in_stream_id      (in_stream_id),
    .in_payload_given  (in_payload_given),
    .csid              (csid_r),
    .job               (front_job)
  );

  rtmpche_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (in_accept),
    .wr_data (front_job),
    .rd_en   (q_pop),
    .rd_data (q_head),
    .q_valid (q_valid),
    .q_full  (q_full)
  );

  rtmpche_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_data          (q_head),
    .q_valid         (q_valid),
    .q_pop           (q_pop),
    .pop             (pop),
    .empty           (empty),
    .out_header_byte (out_header_byte),
    .out_last_byte   (out_last_byte)
  );

endmodule
